FILE: rtl/core/lpl_pkg.sv
`timescale 1ns / 1ps

package lpl_pkg;

  // Storage geometry.
  localparam int BUF_DEPTH   = 1024;
  localparam int SCAN_STRIDE = 4;
  localparam int ADDR_W      = $clog2(BUF_DEPTH);
  localparam int CNT_W       = $clog2(BUF_DEPTH + 1);
  localparam int KW          = $clog2(BUF_DEPTH + SCAN_STRIDE);

  // Field and register widths.
  localparam int SAMPLE_W   = 24;
  localparam int GAIN_W     = 24;
  localparam int CEIL_W     = 23;
  localparam int LA_W       = 10;
  localparam int CMP_W      = (LA_W > KW) ? LA_W : KW;
  localparam int PAIR_W     = 2 * SAMPLE_W;
  localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = CEIL_W;

  // Gain and limit constants.
  localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(8388608);
  localparam logic [CEIL_W-1:0] CEIL_MAX   = CEIL_W'(8304721);
  localparam logic [LA_W-1:0]   LA_RESET   = LA_W'(240);
  localparam logic [CMP_W-1:0]  DIST_MAX   = CMP_W'(BUF_DEPTH - 10);
  localparam int                DIV_STEPS  = GAIN_W - 1;
  localparam int                DIV_CNT_W  = $clog2(DIV_STEPS);

  // Rise step: ceil(x / 1000) computed as floor((x + 999) * RECIP_MULT >> RECIP_SHIFT).
  // The reciprocal error stays below one step for x under 2^24.
  localparam logic [GAIN_W-1:0] RISE_ROUND  = GAIN_W'(999);
  localparam int                RECIP_SHIFT = 34;
  localparam logic [24:0]       RECIP_MULT  = 25'd17179870;
  localparam int                RECIP_W     = GAIN_W + 25;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CEILING   = 1'b0,
    CFG_LOOKAHEAD = 1'b1
  } cfg_reg_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_LAST,
    ST_FETCH,
    ST_DIV,
    ST_ENV,
    ST_RISE,
    ST_MUL_L,
    ST_MUL_R,
    ST_FIN
  } state_e;

  // Ring buffer slot that lies steps entries behind base.
  function automatic logic [ADDR_W-1:0] back_idx(input logic [ADDR_W-1:0] base,
                                                 input logic [ADDR_W-1:0] steps);
    logic [ADDR_W:0] sum;
    sum = {1'b0, base} + (ADDR_W+1)'(BUF_DEPTH) - {1'b0, steps};
    if (sum >= (ADDR_W+1)'(BUF_DEPTH)) begin
      sum = sum - (ADDR_W+1)'(BUF_DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

  // Absolute value; the most negative sample maps to 2^23.
  function automatic logic [SAMPLE_W-1:0] magnitude(input logic signed [SAMPLE_W-1:0] s);
    logic [SAMPLE_W-1:0] neg;
    neg = -s;
    return s[SAMPLE_W-1] ? neg : s;
  endfunction

  // Round half up, drop the Q1.23 gain scale and saturate to the sample range.
  function automatic logic signed [SAMPLE_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] r;
    r = (p + PROD_W'(4194304)) >>> 23;
    if (r > PROD_W'(8388607)) begin
      r = PROD_W'(8388607);
    end else if (r < -PROD_W'(8388608)) begin
      r = -PROD_W'(8388608);
    end
    return r[SAMPLE_W-1:0];
  endfunction

endpackage

FILE: rtl/core/lpl_in_if.sv
`timescale 1ns / 1ps

// Input sample pair channel.
interface lpl_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [lpl_pkg::SAMPLE_W-1:0]  left_in;
  logic signed [lpl_pkg::SAMPLE_W-1:0]  right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

FILE: rtl/core/lpl_out_if.sv
`timescale 1ns / 1ps

// Limited output pair channel.
interface lpl_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [lpl_pkg::SAMPLE_W-1:0]  left_out;
  logic signed [lpl_pkg::SAMPLE_W-1:0]  right_out;
  logic        [lpl_pkg::GAIN_W-1:0]    gain_applied;

  modport source (output valid, output left_out, output right_out, output gain_applied,
                  input ready);
  modport sink   (input valid, input left_out, input right_out, input gain_applied,
                  output ready);
endinterface

FILE: rtl/core/lookahead_peak_limiter.sv
`timescale 1ns / 1ps
// Each item is written to the ring buffer, every fourth stored pair within the clamped lookahead
// D is scanned for the peak, and a bit-serial divider runs only when the peak exceeds the ceiling.
// The scan makes one RAM read per scanned pair; a new item is accepted only when the last is done.
// The output register holds a result while the next item is taken and processed.
// Reset: envelope unity, write pointer zero; a fill count makes unwritten slots read as zero,
// so no clearing pass is needed and an item is accepted right after reset.
module lookahead_peak_limiter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lpl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lpl_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  lpl_in_if.sink                           in_ch,
  lpl_out_if.source                        out_ch
);

  lpl_pkg::state_e state_q, state_d;

  logic [lpl_pkg::CEIL_W-1:0]           ceil_q;
  logic [lpl_pkg::LA_W-1:0]             la_q;
  logic [lpl_pkg::ADDR_W-1:0]           wp_q, wp_d;
  logic [lpl_pkg::CNT_W-1:0]            fill_q, fill_d;
  logic [lpl_pkg::GAIN_W-1:0]           env_q, env_d;
  logic signed [lpl_pkg::SAMPLE_W-1:0]  samp_l_q, samp_l_d, samp_r_q, samp_r_d;
  logic [lpl_pkg::CMP_W-1:0]            k_q, k_d;
  logic [lpl_pkg::SAMPLE_W-1:0]         peak_q, peak_d;
  logic                                 scan_pend_q, scan_pend_d;
  logic                                 rd_ok_q, rd_ok_d;
  logic signed [lpl_pkg::SAMPLE_W-1:0]  dly_l_q, dly_l_d, dly_r_q, dly_r_d;
  logic [lpl_pkg::GAIN_W-1:0]           target_q, target_d;
  logic [lpl_pkg::GAIN_W:0]             rem_q, rem_d;
  logic [lpl_pkg::DIV_STEPS-1:0]        quo_q, quo_d;
  logic [lpl_pkg::DIV_CNT_W-1:0]        div_cnt_q, div_cnt_d;
  logic                                 rise_q, rise_d;
  logic [lpl_pkg::RECIP_W-1:0]          recip_q, recip_d;
  logic signed [lpl_pkg::PROD_W-1:0]    prod_l_q, prod_l_d, prod_r_q, prod_r_d;
  logic                                 out_valid_q, out_valid_d;
  logic signed [lpl_pkg::SAMPLE_W-1:0]  out_l_q, out_l_d, out_r_q, out_r_d;
  logic [lpl_pkg::GAIN_W-1:0]           out_g_q, out_g_d;

  logic [lpl_pkg::CEIL_W-1:0]           ceil_v;
  logic [lpl_pkg::CMP_W-1:0]            la_ext, la_dist;
  logic [lpl_pkg::CMP_W-1:0]            k_next;
  logic                                 scan_done;
  logic [lpl_pkg::ADDR_W-1:0]           scan_addr, dly_addr, ram_raddr;
  logic [lpl_pkg::PAIR_W-1:0]           ram_rdata;
  logic signed [lpl_pkg::SAMPLE_W-1:0]  rd_l, rd_r;
  logic [lpl_pkg::SAMPLE_W-1:0]         mag_l, mag_r, pair_mag;
  logic [lpl_pkg::GAIN_W:0]             rem_shift;
  logic                                 div_ge;
  logic [lpl_pkg::GAIN_W:0]             rise_gap;
  logic signed [lpl_pkg::SAMPLE_W-1:0]  mul_s;
  logic signed [lpl_pkg::GAIN_W:0]      env_s;
  logic signed [lpl_pkg::PROD_W-1:0]    mul_p;
  logic                                 in_xfer, out_load;

  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_q == lpl_pkg::ST_IDLE);
  assign out_load     = (state_q == lpl_pkg::ST_FIN) && (!out_valid_q || out_ch.ready);

  assign out_ch.valid        = out_valid_q;
  assign out_ch.left_out     = out_l_q;
  assign out_ch.right_out    = out_r_q;
  assign out_ch.gain_applied = out_g_q;

  // Clamp the configured ceiling and lookahead distance.
  assign ceil_v = (ceil_q > lpl_pkg::CEIL_MAX) ? lpl_pkg::CEIL_MAX : ceil_q;
  assign la_ext = lpl_pkg::CMP_W'(la_q);
  always_comb begin
    if (la_ext == '0) begin
      la_dist = lpl_pkg::CMP_W'(1);
    end else if (la_ext > lpl_pkg::DIST_MAX) begin
      la_dist = lpl_pkg::DIST_MAX;
    end else begin
      la_dist = la_ext;
    end
  end

  // Read address: scan taps, then the delayed slot.
  assign k_next    = k_q + lpl_pkg::CMP_W'(lpl_pkg::SCAN_STRIDE);
  assign scan_done = (k_next >= la_dist);
  assign scan_addr = lpl_pkg::back_idx(wp_q, k_q[lpl_pkg::ADDR_W-1:0]);
  assign dly_addr  = lpl_pkg::back_idx(wp_q, la_dist[lpl_pkg::ADDR_W-1:0]);
  assign ram_raddr = (state_q == lpl_pkg::ST_LAST) ? dly_addr : scan_addr;

  // Sample pair memory; slots at or above the fill count have never been written.
  lpl_ram #(
    .WIDTH (lpl_pkg::PAIR_W),
    .DEPTH (lpl_pkg::BUF_DEPTH)
  ) u_pair_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == lpl_pkg::ST_WRITE),
    .waddr_i (wp_q),
    .wdata_i ({samp_l_q, samp_r_q}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_l     = rd_ok_q ? ram_rdata[lpl_pkg::PAIR_W-1:lpl_pkg::SAMPLE_W] : '0;
  assign rd_r     = rd_ok_q ? ram_rdata[lpl_pkg::SAMPLE_W-1:0] : '0;
  assign mag_l    = lpl_pkg::magnitude(rd_l);
  assign mag_r    = lpl_pkg::magnitude(rd_r);
  assign pair_mag = (mag_l > mag_r) ? mag_l : mag_r;

  // One restoring division step per cycle.
  assign rem_shift = {rem_q[lpl_pkg::GAIN_W-1:0], 1'b0};
  assign div_ge    = (rem_shift >= {1'b0, peak_q});

  // Gap to the target, rounded up before the divide by 1000.
  assign rise_gap = {1'b0, target_q} - {1'b0, env_q} + {1'b0, lpl_pkg::RISE_ROUND};

  // Shared gain multiplier for both channels.
  assign mul_s = (state_q == lpl_pkg::ST_MUL_L) ? dly_l_q : dly_r_q;
  assign env_s = {1'b0, env_q};
  assign mul_p = mul_s * env_s;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lpl_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_d = lpl_pkg::ST_WRITE;
        end
      end
      lpl_pkg::ST_WRITE: state_d = lpl_pkg::ST_SCAN;
      lpl_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_d = lpl_pkg::ST_LAST;
        end
      end
      lpl_pkg::ST_LAST:  state_d = lpl_pkg::ST_FETCH;
      lpl_pkg::ST_FETCH: begin
        if (peak_q > {1'b0, ceil_v}) begin
          state_d = lpl_pkg::ST_DIV;
        end else begin
          state_d = lpl_pkg::ST_ENV;
        end
      end
      lpl_pkg::ST_DIV: begin
        if (div_cnt_q == lpl_pkg::DIV_CNT_W'(lpl_pkg::DIV_STEPS - 1)) begin
          state_d = lpl_pkg::ST_ENV;
        end
      end
      lpl_pkg::ST_ENV:   state_d = lpl_pkg::ST_RISE;
      lpl_pkg::ST_RISE:  state_d = lpl_pkg::ST_MUL_L;
      lpl_pkg::ST_MUL_L: state_d = lpl_pkg::ST_MUL_R;
      lpl_pkg::ST_MUL_R: state_d = lpl_pkg::ST_FIN;
      lpl_pkg::ST_FIN: begin
        if (out_load) begin
          state_d = lpl_pkg::ST_IDLE;
        end
      end
      default: state_d = lpl_pkg::ST_IDLE;
    endcase
  end

  // Datapath updates per state.
  always_comb begin
    wp_d        = wp_q;
    fill_d      = fill_q;
    env_d       = env_q;
    samp_l_d    = samp_l_q;
    samp_r_d    = samp_r_q;
    k_d         = k_q;
    peak_d      = peak_q;
    dly_l_d     = dly_l_q;
    dly_r_d     = dly_r_q;
    target_d    = target_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    div_cnt_d   = div_cnt_q;
    rise_d      = rise_q;
    recip_d     = recip_q;
    prod_l_d    = prod_l_q;
    prod_r_d    = prod_r_q;
    out_l_d     = out_l_q;
    out_r_d     = out_r_q;
    out_g_d     = out_g_q;
    scan_pend_d = (state_q == lpl_pkg::ST_SCAN);
    rd_ok_d     = (lpl_pkg::CNT_W'(ram_raddr) < fill_q);

    // Fold returning scan data into the running peak.
    if (scan_pend_q && (pair_mag > peak_q)) begin
      peak_d = pair_mag;
    end

    unique case (state_q)
      lpl_pkg::ST_IDLE: begin
        if (in_xfer) begin
          samp_l_d = in_ch.left_in;
          samp_r_d = in_ch.right_in;
        end
      end
      lpl_pkg::ST_WRITE: begin
        if (fill_q != lpl_pkg::CNT_W'(lpl_pkg::BUF_DEPTH)) begin
          fill_d = fill_q + lpl_pkg::CNT_W'(1);
        end
        k_d    = '0;
        peak_d = '0;
      end
      lpl_pkg::ST_SCAN: begin
        k_d = k_next;
      end
      lpl_pkg::ST_LAST: begin
      end
      lpl_pkg::ST_FETCH: begin
        dly_l_d   = rd_l;
        dly_r_d   = rd_r;
        target_d  = lpl_pkg::UNITY_GAIN;
        rem_d     = (lpl_pkg::GAIN_W+1)'(ceil_v);
        quo_d     = '0;
        div_cnt_d = '0;
      end
      lpl_pkg::ST_DIV: begin
        rem_d     = div_ge ? (rem_shift - {1'b0, peak_q}) : rem_shift;
        quo_d     = {quo_q[lpl_pkg::DIV_STEPS-2:0], div_ge};
        div_cnt_d = div_cnt_q + lpl_pkg::DIV_CNT_W'(1);
        target_d  = {1'b0, quo_d};
      end
      lpl_pkg::ST_ENV: begin
        rise_d  = (target_q >= env_q);
        recip_d = rise_gap[lpl_pkg::GAIN_W-1:0] * lpl_pkg::RECIP_MULT;
        if (target_q < env_q) begin
          env_d = target_q;
        end
      end
      lpl_pkg::ST_RISE: begin
        if (rise_q) begin
          env_d = env_q + lpl_pkg::GAIN_W'(recip_q >> lpl_pkg::RECIP_SHIFT);
        end
      end
      lpl_pkg::ST_MUL_L: begin
        prod_l_d = mul_p;
      end
      lpl_pkg::ST_MUL_R: begin
        prod_r_d = mul_p;
      end
      lpl_pkg::ST_FIN: begin
        if (out_load) begin
          out_l_d = lpl_pkg::round_sat(prod_l_q);
          out_r_d = lpl_pkg::round_sat(prod_r_q);
          out_g_d = env_q;
          wp_d    = (wp_q == lpl_pkg::ADDR_W'(lpl_pkg::BUF_DEPTH - 1)) ?
                    '0 : wp_q + lpl_pkg::ADDR_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: loaded at the end of an item, freed by a transfer.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_ch.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lpl_pkg::ST_IDLE;
      wp_q        <= '0;
      fill_q      <= '0;
      env_q       <= lpl_pkg::UNITY_GAIN;
      scan_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
      ceil_q      <= lpl_pkg::CEIL_MAX;
      la_q        <= lpl_pkg::LA_RESET;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      env_q       <= env_d;
      scan_pend_q <= scan_pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          lpl_pkg::CFG_CEILING:   ceil_q <= cfg_data_i[lpl_pkg::CEIL_W-1:0];
          lpl_pkg::CFG_LOOKAHEAD: la_q   <= cfg_data_i[lpl_pkg::LA_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    samp_l_q  <= samp_l_d;
    samp_r_q  <= samp_r_d;
    k_q       <= k_d;
    peak_q    <= peak_d;
    rd_ok_q   <= rd_ok_d;
    dly_l_q   <= dly_l_d;
    dly_r_q   <= dly_r_d;
    target_q  <= target_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    div_cnt_q <= div_cnt_d;
    rise_q    <= rise_d;
    recip_q   <= recip_d;
    prod_l_q  <= prod_l_d;
    prod_r_q  <= prod_r_d;
    out_l_q   <= out_l_d;
    out_r_q   <= out_r_d;
    out_g_q   <= out_g_d;
  end

  // The envelope never rises above unity gain.
  a_env_unity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    env_q <= lpl_pkg::UNITY_GAIN)
    else $error("envelope above unity");

  // Fill count and write pointer stay inside the buffer.
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q <= lpl_pkg::CNT_W'(lpl_pkg::BUF_DEPTH)) &&
    (lpl_pkg::CNT_W'(wp_q) < lpl_pkg::CNT_W'(lpl_pkg::BUF_DEPTH)))
    else $error("fill count or write pointer out of range");

  // No scan read is in flight once the block is idle.
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lpl_pkg::ST_IDLE) |-> !scan_pend_q)
    else $error("scan read pending while idle");

  // An accepted item is written to the buffer in the next cycle.
  a_accept_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == lpl_pkg::ST_WRITE))
    else $error("accepted item not written");

  // A finished item waits while the output register is still occupied.
  a_fin_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == lpl_pkg::ST_FIN) && out_valid_q && !out_ch.ready) |=>
    (state_q == lpl_pkg::ST_FIN))
    else $error("result lost while output register full");

endmodule

FILE: rtl/core/lpl_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module lpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

// One limited output pair as it leaves the block.
typedef struct packed {
  logic signed [lpl_pkg::SAMPLE_W-1:0] left;
  logic signed [lpl_pkg::SAMPLE_W-1:0] right;
  logic        [lpl_pkg::GAIN_W-1:0]   gain;
} limited_pair_t;

// Tracks the limiter state and holds the limited pairs still owed by the block.
class limiter_board;
  logic signed [lpl_pkg::SAMPLE_W-1:0] hist_left [lpl_pkg::BUF_DEPTH];
  logic signed [lpl_pkg::SAMPLE_W-1:0] hist_right [lpl_pkg::BUF_DEPTH];
  logic        [lpl_pkg::GAIN_W-1:0]   envelope;
  logic        [lpl_pkg::CEIL_W-1:0]   ceiling;
  logic        [lpl_pkg::LA_W-1:0]     lookahead;
  int unsigned                         slot;
  limited_pair_t                       pending_outputs[$];

  function new();
    for (int i = 0; i < lpl_pkg::BUF_DEPTH; i++) begin
      hist_left[i]  = '0;
      hist_right[i] = '0;
    end
    slot      = 0;
    envelope  = lpl_pkg::UNITY_GAIN;
    ceiling   = lpl_pkg::CEIL_MAX;
    lookahead = lpl_pkg::LA_RESET;
  endfunction

  function void set_register(lpl_pkg::cfg_reg_e which,
                             logic [lpl_pkg::CFG_DATA_W-1:0] value);
    if (which == lpl_pkg::CFG_CEILING) begin
      ceiling = value[lpl_pkg::CEIL_W-1:0];
    end else if (which == lpl_pkg::CFG_LOOKAHEAD) begin
      lookahead = value[lpl_pkg::LA_W-1:0];
    end
  endfunction

  static function logic [lpl_pkg::SAMPLE_W-1:0] abs_sample(
      logic signed [lpl_pkg::SAMPLE_W-1:0] s);
    logic [lpl_pkg::SAMPLE_W-1:0] flipped;
    flipped = -s;
    return s[lpl_pkg::SAMPLE_W-1] ? flipped : s;
  endfunction

  // Multiply by a Q1.23 gain, round half up and saturate.
  static function logic signed [lpl_pkg::SAMPLE_W-1:0] scale_sample(
      logic signed [lpl_pkg::SAMPLE_W-1:0] s, logic [lpl_pkg::GAIN_W-1:0] g);
    longint prod;
    prod = longint'(s) * longint'(g) + 64'sd4194304;
    prod = prod >>> 23;
    if (prod > 64'sd8388607) begin
      prod = 64'sd8388607;
    end
    if (prod < -64'sd8388608) begin
      prod = -64'sd8388608;
    end
    return lpl_pkg::SAMPLE_W'(prod);
  endfunction

  // Store one accepted pair and work out the limited pair it produces.
  function void note_input(logic signed [lpl_pkg::SAMPLE_W-1:0] l,
                           logic signed [lpl_pkg::SAMPLE_W-1:0] r);
    logic [lpl_pkg::CEIL_W-1:0]   limit;
    logic [lpl_pkg::SAMPLE_W-1:0] peak;
    logic [lpl_pkg::SAMPLE_W-1:0] mag_l;
    logic [lpl_pkg::SAMPLE_W-1:0] mag_r;
    logic [lpl_pkg::GAIN_W-1:0]   goal;
    logic [47:0]                  num;
    int unsigned                  span;
    int unsigned                  idx;
    limited_pair_t                res;
    limit = (ceiling > lpl_pkg::CEIL_MAX) ? lpl_pkg::CEIL_MAX : ceiling;
    span  = lookahead;
    if (span < 1) begin
      span = 1;
    end
    if (span > lpl_pkg::BUF_DEPTH - 10) begin
      span = lpl_pkg::BUF_DEPTH - 10;
    end
    hist_left[slot]  = l;
    hist_right[slot] = r;

    // Peak over every fourth stored pair, newest first.
    peak = '0;
    for (int k = 0; k < span; k += lpl_pkg::SCAN_STRIDE) begin
      idx   = (slot + lpl_pkg::BUF_DEPTH - k) % lpl_pkg::BUF_DEPTH;
      mag_l = abs_sample(hist_left[idx]);
      mag_r = abs_sample(hist_right[idx]);
      if (mag_l > peak) begin
        peak = mag_l;
      end
      if (mag_r > peak) begin
        peak = mag_r;
      end
    end

    // Target gain, then instant fall or slow rise of the envelope.
    goal = lpl_pkg::UNITY_GAIN;
    if (peak > lpl_pkg::GAIN_W'(limit)) begin
      num  = 48'(limit) << 23;
      goal = lpl_pkg::GAIN_W'(num / 48'(peak));
    end
    if (goal < envelope) begin
      envelope = goal;
    end else begin
      envelope = envelope +
                 lpl_pkg::GAIN_W'((32'(goal - envelope) + 32'd999) / 32'd1000);
    end

    idx       = (slot + lpl_pkg::BUF_DEPTH - span) % lpl_pkg::BUF_DEPTH;
    res.left  = scale_sample(hist_left[idx], envelope);
    res.right = scale_sample(hist_right[idx], envelope);
    res.gain  = envelope;
    pending_outputs.push_back(res);
    slot = (slot + 1) % lpl_pkg::BUF_DEPTH;
  endfunction

  function int pending();
    return pending_outputs.size();
  endfunction

  // Compare one output transfer with the oldest owed pair; empty string when it matches.
  function string check_output(limited_pair_t seen);
    limited_pair_t want;
    string         msg;
    if (pending_outputs.size() == 0) begin
      return $sformatf("output transfer with nothing outstanding: %0d %0d gain %0d",
                       seen.left, seen.right, seen.gain);
    end
    want = pending_outputs.pop_front();
    msg  = "";
    if (seen.left !== want.left) begin
      msg = {msg, $sformatf(" left_out got %0d want %0d;", seen.left, want.left)};
    end
    if (seen.right !== want.right) begin
      msg = {msg, $sformatf(" right_out got %0d want %0d;", seen.right, want.right)};
    end
    if (seen.gain !== want.gain) begin
      msg = {msg, $sformatf(" gain_applied got %0d want %0d;", seen.gain, want.gain)};
    end
    return msg;
  endfunction
endclass

module testbench;

  localparam int unsigned CYCLE_LIMIT  = 3000000;
  localparam int          RANDOM_ITEMS = 1480;
  localparam int          TAIL_CYCLES  = 300;
  localparam int          HOLD_CYCLES  = 600;
  localparam int          PRINT_CAP    = 100;

  localparam logic signed [lpl_pkg::SAMPLE_W-1:0] SAMPLE_TOP    = 24'sh7FFFFF;
  localparam logic signed [lpl_pkg::SAMPLE_W-1:0] SAMPLE_BOTTOM = 24'sh800000;
  localparam logic [lpl_pkg::CFG_DATA_W-1:0]      CEIL_FULL     = 23'h7FFFFF;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [lpl_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [lpl_pkg::CFG_DATA_W-1:0] cfg_data_i;

  lpl_in_if  in_ch ();
  lpl_out_if out_ch ();

  lookahead_peak_limiter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  limiter_board board = new();

  int unsigned cycle_count = 0;
  int          mismatches  = 0;
  int          hold_request = 0;
  bit          offering = 1'b0;
  bit          source_calm = 1'b0;
  bit          loud = 1'b0;
  int          fed_count = 0;

  always #2 clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report(string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("mismatch at cycle %0d:%s", cycle_count, what);
    end
  endtask

  // Sender pacing: runs of back-to-back transfers alternate with random gaps.
  function automatic int draw_gap();
    if (fed_count % 32 == 0) begin
      source_calm = ($urandom_range(0, 3) == 0);
    end
    return source_calm ? 0 : $urandom_range(0, 16);
  endfunction

  // Samples come in loud and quiet stretches so the envelope both falls and recovers.
  function automatic logic signed [lpl_pkg::SAMPLE_W-1:0] draw_sample();
    logic signed [lpl_pkg::SAMPLE_W-1:0] s;
    int unsigned                         m;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: s = SAMPLE_TOP;
          1: s = SAMPLE_BOTTOM;
          2: s = '0;
          3: s = 24'sd1;
          default: s = -24'sd1;
        endcase
      end
      1, 2, 3: begin
        if (loud) begin
          m = $urandom_range(4194304, 8388607);
          s = lpl_pkg::SAMPLE_W'(m);
          if ($urandom_range(0, 1) == 1) begin
            s = -s;
          end
        end else begin
          s = lpl_pkg::SAMPLE_W'($urandom);
        end
      end
      default: begin
        s = lpl_pkg::SAMPLE_W'($urandom);
        s = s >>> $urandom_range(loud ? 0 : 2, 9);
      end
    endcase
    return s;
  endfunction

  // Offer one pair and wait for its transfer.
  task automatic send_pair(logic signed [lpl_pkg::SAMPLE_W-1:0] l,
                           logic signed [lpl_pkg::SAMPLE_W-1:0] r);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      if (offering) begin
        in_ch.valid <= 1'b0;
      end
      offering = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.left_in  <= l;
    in_ch.right_in <= r;
    offering = 1'b1;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    board.note_input(l, r);
    fed_count++;
  endtask

  // Stop offering and wait until every owed pair has come out.
  task automatic quiesce();
    if (offering) begin
      in_ch.valid <= 1'b0;
    end
    offering = 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Write both registers while the block is idle.
  task automatic set_limits(logic [lpl_pkg::CFG_DATA_W-1:0] top_gain,
                            logic [lpl_pkg::CFG_DATA_W-1:0] span_word);
    quiesce();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= lpl_pkg::CFG_CEILING;
    cfg_data_i <= top_gain;
    @(posedge clk_i);
    cfg_idx_i  <= lpl_pkg::CFG_LOOKAHEAD;
    cfg_data_i <= span_word;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    board.set_register(lpl_pkg::CFG_CEILING, top_gain);
    board.set_register(lpl_pkg::CFG_LOOKAHEAD, span_word);
  endtask

  // Output side: random stalls, calm stretches and one long hold-off on request.
  initial begin : sink_side
    int            stall;
    int            taken;
    bit            sink_calm;
    limited_pair_t seen;
    string         msg;
    taken     = 0;
    sink_calm = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_request > 0) begin
        out_ch.ready <= 1'b0;
        for (int c = 0; c < hold_request; c++) @(posedge clk_i);
        hold_request = 0;
      end
      if (taken % 40 == 0) begin
        sink_calm = ($urandom_range(0, 3) == 0);
      end
      stall = sink_calm ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (out_ch.valid !== 1'b1);
      seen.left  = out_ch.left_out;
      seen.right = out_ch.right_out;
      seen.gain  = out_ch.gain_applied;
      msg = board.check_output(seen);
      if (msg != "") begin
        report(msg);
      end
      taken++;
    end
  end

  // Stimulus sequence.
  initial begin : source_side
    int                             phase_no;
    int                             count;
    int unsigned                    span;
    logic [lpl_pkg::CFG_DATA_W-1:0] top_gain;
    logic [lpl_pkg::CFG_DATA_W-1:0] span_word;
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= lpl_pkg::CFG_CEILING;
    cfg_data_i     <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.left_in  <= '0;
    in_ch.right_in <= '0;
    out_ch.ready   <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Default limits: extremes, peak exactly at and just over the ceiling.
    set_limits(lpl_pkg::CEIL_MAX, 23'd240);
    send_pair('0, '0);
    send_pair(SAMPLE_TOP, SAMPLE_BOTTOM);
    send_pair(SAMPLE_BOTTOM, SAMPLE_TOP);
    send_pair(24'sd8304721, -24'sd8304721);
    send_pair(24'sd8304722, '0);
    send_pair(-24'sd1, 24'sd1);
    send_pair('0, '0);

    // Ceiling above the 0.99 clamp, zero lookahead.
    set_limits(CEIL_FULL, 23'd0);
    send_pair(SAMPLE_TOP, '0);
    send_pair(SAMPLE_BOTTOM, SAMPLE_BOTTOM);
    send_pair('0, '0);
    send_pair(24'sd12345, -24'sd12345);

    // Zero ceiling with the longest lookahead word.
    set_limits('0, 23'd1023);
    send_pair(24'sd1, '0);
    send_pair('0, '0);
    send_pair(SAMPLE_BOTTOM, SAMPLE_TOP);
    send_pair(-24'sd1, -24'sd1);

    // Lookahead just past the clamp, half-scale ceiling.
    set_limits(lpl_pkg::CEIL_MAX >> 1, 23'd1015);
    send_pair(24'sd4194304, -24'sd4194305);
    send_pair('0, '0);
    send_pair(SAMPLE_TOP, SAMPLE_TOP);

    // Tiny ceiling, lookahead equal to the scan stride.
    set_limits(23'd1, 23'd4);
    send_pair(24'sd2, 24'sd1);
    send_pair(24'sd1, 24'sd1);
    send_pair('0, -24'sd2);

    // Random phases, mostly with short lookahead.
    phase_no = 0;
    count    = 0;
    while (count < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0: top_gain = '0;
        1: top_gain = lpl_pkg::CEIL_MAX;
        2: top_gain = CEIL_FULL;
        3: top_gain = lpl_pkg::CFG_DATA_W'($urandom_range(lpl_pkg::CEIL_MAX + 1, CEIL_FULL));
        4: top_gain = lpl_pkg::CFG_DATA_W'($urandom);
        default: top_gain = lpl_pkg::CFG_DATA_W'($urandom_range(1 << 20, lpl_pkg::CEIL_MAX));
      endcase
      case ($urandom_range(0, 6))
        0: span = 0;
        1: span = $urandom_range(1015, 1023);
        2: span = $urandom_range(65, 1014);
        3: span = $urandom_range(17, 64);
        default: span = $urandom_range(1, 16);
      endcase
      if (phase_no == 0) begin
        span = 8;
      end
      span_word = {13'($urandom), lpl_pkg::LA_W'(span)};
      set_limits(top_gain, span_word);
      if (phase_no == 0) begin
        hold_request = HOLD_CYCLES;
      end
      for (int i = 0; i < ((span > 256) ? 40 : 160); i++) begin
        if (phase_no == 1 && i == 30) begin
          quiesce();
        end
        if ($urandom_range(0, 23) == 0) begin
          loud = ~loud;
        end
        send_pair(draw_sample(), draw_sample());
        count++;
      end
      phase_no++;
    end

    // Drain, then watch for stray output transfers.
    quiesce();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
